// ===== src/fupd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the file URI percent decoder.
package fupd_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W = $clog2(MAX_RESULTS);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam int PREFIX_LEN = 7;
    localparam logic [2:0] PREFIX_LEN_C = 3'(PREFIX_LEN);
    localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
        8'h66, 8'h69, 8'h6C, 8'h65, 8'h3A, 8'h2F, 8'h2F
    };
    localparam logic [7:0] ESC_CHAR = 8'h25;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] PHASE_NORMAL = 2'd0;
    localparam logic [1:0] PHASE_PERCENT = 2'd1;
    localparam logic [1:0] PHASE_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } fupd_result_t;

    typedef struct packed {
        logic [CNT_W-1:0]                   cnt;
        fupd_result_t [MAX_RESULTS-1:0]     slot;
    } fupd_bundle_t;

    typedef struct packed {
        logic         push;
        fupd_bundle_t bundle;
    } fupd_wr_t;

    typedef struct packed {
        logic         valid;
        fupd_bundle_t bundle;
    } fupd_head_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== src/fupd_front.sv =====
`timescale 1ns / 1ps
// Front end: prefix check, escape tracking and result bundle formation per beat.
module fupd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output fupd_pkg::fupd_wr_t wr
);
    import fupd_pkg::*;

    logic [2:0] prefix_count_reg, prefix_count_next;
    logic [1:0] escape_phase_reg, escape_phase_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic       rejected_reg, rejected_next;
    fupd_bundle_t bundle;

    function automatic fupd_bundle_t add_res(input fupd_bundle_t bnd, input logic [7:0] data,
                                             input logic [1:0] kind, input logic last);
        fupd_bundle_t r;
        r = bnd;
        r.slot[bnd.cnt[SLOT_W-1:0]] = '{data: data, kind: kind, last: last};
        r.cnt = bnd.cnt + CNT_W'(1);
        return r;
    endfunction

    always_comb begin
        bundle = '0;
        prefix_count_next = prefix_count_reg;
        escape_phase_next = escape_phase_reg;
        held_digit_next = held_digit_reg;
        rejected_next = rejected_reg;

        if (!rejected_reg) begin
            if (prefix_count_reg < PREFIX_LEN_C) begin
                if (in_byte == PREFIX_TEXT[prefix_count_reg]) begin
                    prefix_count_next = prefix_count_reg + 3'd1;
                end else begin
                    rejected_next = 1'b1;
                end
            end else if (escape_phase_reg == PHASE_DIGIT) begin
                if (is_hex(in_byte)) begin
                    bundle = add_res(bundle, {hex_value(held_digit_reg), hex_value(in_byte)},
                                     KIND_DATA, 1'b0);
                    escape_phase_next = PHASE_NORMAL;
                end else begin
                    bundle = add_res(bundle, ESC_CHAR, KIND_DATA, 1'b0);
                    bundle = add_res(bundle, held_digit_reg, KIND_DATA, 1'b0);
                    if (in_byte == ESC_CHAR) begin
                        escape_phase_next = PHASE_PERCENT;
                    end else begin
                        escape_phase_next = PHASE_NORMAL;
                        bundle = add_res(bundle, in_byte, KIND_DATA, 1'b0);
                    end
                end
            end else if (escape_phase_reg == PHASE_PERCENT) begin
                if (is_hex(in_byte)) begin
                    held_digit_next = in_byte;
                    escape_phase_next = PHASE_DIGIT;
                end else begin
                    bundle = add_res(bundle, ESC_CHAR, KIND_DATA, 1'b0);
                    if (in_byte == ESC_CHAR) begin
                        escape_phase_next = PHASE_PERCENT;
                    end else begin
                        escape_phase_next = PHASE_NORMAL;
                        bundle = add_res(bundle, in_byte, KIND_DATA, 1'b0);
                    end
                end
            end else begin
                if (in_byte == ESC_CHAR) begin
                    escape_phase_next = PHASE_PERCENT;
                end else begin
                    escape_phase_next = PHASE_NORMAL;
                    bundle = add_res(bundle, in_byte, KIND_DATA, 1'b0);
                end
            end
        end

        if (in_last) begin
            if (rejected_next || prefix_count_next < PREFIX_LEN_C) begin
                bundle = add_res(bundle, 8'h00, KIND_REJECT, 1'b1);
            end else begin
                if (escape_phase_next == PHASE_PERCENT || escape_phase_next == PHASE_DIGIT) begin
                    bundle = add_res(bundle, ESC_CHAR, KIND_DATA, 1'b0);
                end
                if (escape_phase_next == PHASE_DIGIT) begin
                    bundle = add_res(bundle, held_digit_next, KIND_DATA, 1'b0);
                end
                bundle = add_res(bundle, 8'h00, KIND_END, 1'b1);
            end
            prefix_count_next = '0;
            escape_phase_next = PHASE_NORMAL;
            held_digit_next = '0;
            rejected_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_count_reg <= '0;
            escape_phase_reg <= PHASE_NORMAL;
            held_digit_reg <= '0;
            rejected_reg <= 1'b0;
        end else if (accept) begin
            prefix_count_reg <= prefix_count_next;
            escape_phase_reg <= escape_phase_next;
            held_digit_reg <= held_digit_next;
            rejected_reg <= rejected_next;
        end
    end

    assign wr.push = accept && (bundle.cnt != '0);
    assign wr.bundle = bundle;

endmodule

// ===== src/fupd_queue.sv =====
`timescale 1ns / 1ps
// Bundle queue between the front end and the output serializer.
module fupd_queue #(
    parameter int DEPTH = fupd_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fupd_pkg::fupd_wr_t   wr,
    input  logic                 pop,
    output logic                 full,
    output fupd_pkg::fupd_head_t head
);
    import fupd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

    fupd_bundle_t   entries [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg, count_next;
    logic           do_pop;

    assign full = (count_reg == DEPTH_C);
    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (wr.push && !do_pop) begin
            count_next = count_reg + (AW + 1)'(1);
        end else if (!wr.push && do_pop) begin
            count_next = count_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            entries[wr_ptr_reg] <= wr.bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.bundle = entries[rd_ptr_reg];

endmodule

// ===== src/fupd_back.sv =====
`timescale 1ns / 1ps
// Back end: hands out the results of each queued bundle one beat at a time.
module fupd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fupd_pkg::fupd_head_t head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic [1:0]           m_out_kind,
    output logic                 m_out_last
);
    import fupd_pkg::*;

    logic [SLOT_W-1:0] sel_reg;
    logic              m_valid_reg;
    fupd_result_t      out_reg;
    logic              load;
    logic [SLOT_W-1:0] last_sel;

    assign load = head.valid && (!m_valid_reg || m_ready);
    assign last_sel = SLOT_W'(head.bundle.cnt - CNT_W'(1));
    assign pop = load && (sel_reg == last_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                sel_reg <= pop ? '0 : sel_reg + SLOT_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= head.bundle.slot[sel_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = out_reg.data;
    assign m_out_kind = out_reg.kind;
    assign m_out_last = out_reg.last;

endmodule

// ===== src/file_uri_percent_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the file URI percent decoder.
// Results of an accepted beat are written into the bundle queue, then loaded into the m_ output register.
// Throughput: one input beat per cycle while each beat yields at most one result and m_ready holds high.
// A beat with k results passes through the single output register one result at a time; the queue absorbs bursts.
// Reset clears the prefix and escape state and empties the bundle queue.
module file_uri_percent_decoder #(
    parameter int QUEUE_DEPTH = fupd_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_out_last
);
    import fupd_pkg::*;

    fupd_wr_t   wr;
    fupd_head_t head;
    logic       full;
    logic       pop;
    logic       accept;

    assign s_ready = !full;
    assign accept = s_valid && s_ready;

    fupd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .wr      (wr)
    );

    fupd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .pop     (pop),
        .full    (full),
        .head    (head)
    );

    fupd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_kind (m_out_kind),
        .m_out_last (m_out_last)
    );

endmodule

// ===== src/fupd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the file URI percent decoder and its bind to the top level.
module fupd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_in_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_out_kind,
    input logic       m_out_last
);
    import fupd_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_kind)
            && $stable(m_out_last))
        else $error("Result beat changed while stalled.");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_kind == KIND_DATA || m_out_kind == KIND_END
            || m_out_kind == KIND_REJECT))
        else $error("Result beat carries an undefined kind.");

    a_last_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_last == (m_out_kind != KIND_DATA)))
        else $error("Last flag disagrees with the result kind.");

    a_final_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_last |-> m_out_byte == 8'h00)
        else $error("End or rejected beat carries a nonzero byte.");

endmodule

bind file_uri_percent_decoder fupd_checker u_fupd_checker (.*);

// ===== verif/tb_file_uri_percent_decoder.sv =====
`timescale 1ns / 1ps
// Testbench for the file URI percent decoder: directed and random URIs, checked against a predictor.
module tb_file_uri_percent_decoder;
    import fupd_pkg::*;

    localparam int MAX_IDLE = 17;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_BEATS = 40;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_in_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic [1:0] m_out_kind;
    logic       m_out_last;

    fupd_result_t exp_results[$];
    fupd_result_t head_result;
    logic [7:0]   uri_bytes[$];

    logic [2:0] pfx_matched;
    logic [1:0] esc_state;
    logic [7:0] first_digit;
    logic       uri_bad;

    bit s_pause_on;
    bit m_pause_on;
    int beat_count;
    int mismatch_count;
    int cycle_count;

    file_uri_percent_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_out_kind(m_out_kind),
        .m_out_last(m_out_last)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit hex_digit(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= "0" && c <= "9") || (folded >= "a" && folded <= "f");
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic void add_result(input logic [7:0] d, input logic [1:0] k, input logic t);
        fupd_result_t r;
        r.data = d;
        r.kind = k;
        r.last = t;
        exp_results.push_back(r);
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == ESC_CHAR) begin
            esc_state = PHASE_PERCENT;
        end else begin
            esc_state = PHASE_NORMAL;
            add_result(b, KIND_DATA, 1'b0);
        end
    endfunction

    function automatic void clear_uri_state();
        pfx_matched = '0;
        esc_state = PHASE_NORMAL;
        first_digit = '0;
        uri_bad = 1'b0;
    endfunction

    function automatic void decode_beat(input logic [7:0] b, input logic l);
        if (!uri_bad) begin
            if (pfx_matched < PREFIX_LEN_C) begin
                if (b == PREFIX_TEXT[pfx_matched]) begin
                    pfx_matched = pfx_matched + 3'd1;
                end else begin
                    uri_bad = 1'b1;
                end
            end else begin
                case (esc_state)
                    PHASE_DIGIT: begin
                        if (hex_digit(b)) begin
                            add_result({nibble_of(first_digit), nibble_of(b)}, KIND_DATA, 1'b0);
                            esc_state = PHASE_NORMAL;
                        end else begin
                            add_result(ESC_CHAR, KIND_DATA, 1'b0);
                            add_result(first_digit, KIND_DATA, 1'b0);
                            take_plain(b);
                        end
                    end
                    PHASE_PERCENT: begin
                        if (hex_digit(b)) begin
                            first_digit = b;
                            esc_state = PHASE_DIGIT;
                        end else begin
                            add_result(ESC_CHAR, KIND_DATA, 1'b0);
                            take_plain(b);
                        end
                    end
                    default: take_plain(b);
                endcase
            end
        end
        if (l) begin
            if (uri_bad || pfx_matched < PREFIX_LEN_C) begin
                add_result(8'h00, KIND_REJECT, 1'b1);
            end else begin
                if (esc_state != PHASE_NORMAL) add_result(ESC_CHAR, KIND_DATA, 1'b0);
                if (esc_state == PHASE_DIGIT) add_result(first_digit, KIND_DATA, 1'b0);
                add_result(8'h00, KIND_END, 1'b1);
            end
            clear_uri_state();
        end
    endfunction

    task automatic note_mismatch(input string what, input fupd_result_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: expected byte %02h kind %0d last %0d, got byte %02h kind %0d last %0d",
                     what, want.data, want.kind, want.last, m_out_byte, m_out_kind, m_out_last);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_results.size() == 0) begin
                note_mismatch("unexpected beat", '0);
            end else begin
                head_result = exp_results.pop_front();
                if (m_out_byte !== head_result.data || m_out_kind !== head_result.kind ||
                        m_out_last !== head_result.last) begin
                    note_mismatch("result mismatch", head_result);
                end
            end
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = m_pause_on ? $urandom_range(0, MAX_IDLE) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        int gap;
        gap = s_pause_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_in_byte = b;
        s_in_last = l;
        do @(posedge aclk); while (!s_ready);
        decode_beat(b, l);
        beat_count++;
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) uri_bytes.push_back(t[i]);
    endtask

    task automatic send_bytes(input bit with_last);
        for (int i = 0; i < uri_bytes.size(); i++) begin
            send_beat(uri_bytes[i], with_last && (i == uri_bytes.size() - 1));
        end
        uri_bytes.delete();
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (exp_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_digit(c));
        return c;
    endfunction

    task automatic build_random_uri();
        int len;
        int pick;
        if ($urandom_range(0, 99) < 12) begin
            len = $urandom_range(1, PREFIX_LEN);
            for (int i = 0; i < len; i++) uri_bytes.push_back(PREFIX_TEXT[i]);
            if ($urandom_range(0, 1)) begin
                uri_bytes[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
            end
            repeat ($urandom_range(0, 4)) uri_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            push_text("file://");
            repeat ($urandom_range(0, 10)) begin
                pick = $urandom_range(0, 9);
                if (pick <= 3) begin
                    uri_bytes.push_back(ESC_CHAR);
                    uri_bytes.push_back(random_hex());
                    uri_bytes.push_back(random_hex());
                end else if (pick == 4) begin
                    uri_bytes.push_back(ESC_CHAR);
                end else if (pick == 5) begin
                    uri_bytes.push_back(ESC_CHAR);
                    uri_bytes.push_back(random_hex());
                    uri_bytes.push_back(random_non_hex());
                end else if (pick == 6) begin
                    uri_bytes.push_back(ESC_CHAR);
                    uri_bytes.push_back(ESC_CHAR);
                end else begin
                    uri_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic test_prefix_only();
        push_text("file://");
        send_bytes(1'b1);
    endtask

    task automatic test_prefix_cut_short();
        push_text("fil");
        send_bytes(1'b1);
    endtask

    task automatic test_prefix_mismatch();
        uri_bytes.push_back(8'h00);
        push_text("i");
        uri_bytes.push_back(8'hFF);
        send_bytes(1'b1);
    endtask

    task automatic test_escapes();
        push_text("file://%6a%fF%00");
        uri_bytes.push_back(8'h01);
        uri_bytes.push_back(8'hFF);
        uri_bytes.push_back(8'h00);
        push_text("%4g%%41%");
        send_bytes(1'b1);
    endtask

    task automatic test_hold_mid_escape();
        push_text("file://a%4");
        send_bytes(1'b0);
        wait_for_drain();
        push_text("1B");
        send_bytes(1'b1);
    endtask

    task automatic test_random_uris(input int beat_goal, input bit s_pause, input bit m_pause);
        int start;
        start = beat_count;
        s_pause_on = s_pause;
        m_pause_on = m_pause;
        while (beat_count - start < beat_goal) begin
            build_random_uri();
            send_bytes(1'b1);
        end
        wait_for_drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_in_last = 1'b0;
        s_pause_on = 1'b0;
        m_pause_on = 1'b0;
        clear_uri_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_prefix_only();
        test_prefix_cut_short();
        test_prefix_mismatch();
        test_escapes();
        test_hold_mid_escape();
        test_random_uris(PHASE_BEATS, 1'b0, 1'b0);
        test_random_uris(PHASE_BEATS, 1'b1, 1'b1);
        test_random_uris(PHASE_BEATS, 1'b1, 1'b0);
        test_random_uris(PHASE_BEATS, 1'b0, 1'b1);
        wait_for_drain();

        if (mismatch_count == 0 && exp_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== file_uri_percent_decoder.f =====
src/fupd_pkg.sv
src/fupd_front.sv
src/fupd_queue.sv
src/fupd_back.sv
src/file_uri_percent_decoder.sv
src/fupd_checker.sv
verif/tb_file_uri_percent_decoder.sv
